// ===== design/rcfu_pkg.sv =====
// Package for the link frame channel unpacker: constants, register indexes
// and the structs passed between the unpacker's modules.
// No dependencies.
package rcfu_pkg;

    localparam int BYTE_W       = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int TOTAL_W      = 9;
    localparam int HEADER_EXTRA = 2;
    localparam int TYPE_POS     = 2;
    localparam int NUM_CHANNELS = 16;
    localparam int CHAN_BITS    = 11;
    localparam int CHAN_IDX_W   = 4;
    localparam int PAYLOAD_BYTES = 22;
    localparam int STORE_BYTES  = PAYLOAD_BYTES + 1;
    localparam int PAYLOAD_W    = PAYLOAD_BYTES * BYTE_W;

    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hC8;
    localparam logic [BYTE_W-1:0] TYPE_RESET = 8'h16;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_VALUE         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_FRAME_TYPE = 2'd1;

    localparam logic [CHAN_IDX_W-1:0] LAST_CHANNEL = 4'(NUM_CHANNELS - 1);

    typedef struct packed {
        logic [BYTE_W-1:0] sync_value;
        logic [BYTE_W-1:0] channel_frame_type;
    } t_cfg;

    typedef struct packed {
        logic                 load;
        logic [PAYLOAD_W-1:0] payload;
    } t_frame_load;

endpackage

// ===== design/rcfu_cfg_regs.sv =====
// Configuration registers of the link frame channel unpacker.
// Depends on rcfu_pkg.
module rcfu_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [rcfu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rcfu_pkg::BYTE_W-1:0]     i_cfg_data,
    output rcfu_pkg::t_cfg                  o_cfg
);
    import rcfu_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SYNC_VALUE:         n_cfg.sync_value = i_cfg_data;
                CFG_CHANNEL_FRAME_TYPE: n_cfg.channel_frame_type = i_cfg_data;
                default:                n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_value         <= SYNC_RESET;
            r_cfg.channel_frame_type <= TYPE_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/rcfu_parser.sv =====
// Frame tracker of the link frame channel unpacker: sync hunt, length check,
// type and payload byte store, channel frame detection. Depends on rcfu_pkg.
module rcfu_parser #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [rcfu_pkg::BYTE_W-1:0]  i_rx_byte,
    input  rcfu_pkg::t_cfg               i_cfg,
    output rcfu_pkg::t_frame_load        o_load,
    output logic                         o_last_pending
);
    import rcfu_pkg::*;

    localparam int POS_W = $clog2(BUFFER_BYTES + 1);
    localparam logic [TOTAL_W-1:0] BUF_LIM = TOTAL_W'(BUFFER_BYTES);

    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;
    logic [POS_W-1:0]  r_total;
    logic [POS_W-1:0]  n_total;
    logic [BYTE_W-1:0] r_store [STORE_BYTES];
    logic [BYTE_W-1:0] n_store [STORE_BYTES];
    logic [TOTAL_W-1:0] len_total;
    logic [POS_W-1:0]  pos_inc;
    t_frame_load       load;

    assign len_total = TOTAL_W'(i_rx_byte) + TOTAL_W'(HEADER_EXTRA);
    assign pos_inc   = r_pos + POS_W'(1);

    always_comb begin
        for (int i = 0; i < STORE_BYTES; i++) begin
            n_store[i] = r_store[i];
            if (i_accept && (r_pos == POS_W'(i + TYPE_POS))) begin
                n_store[i] = i_rx_byte;
            end
        end
    end

    always_comb begin
        for (int j = 0; j < PAYLOAD_BYTES; j++) begin
            load.payload[j*BYTE_W +: BYTE_W] = n_store[j + 1];
        end
        n_pos     = r_pos;
        n_total   = r_total;
        load.load = 1'b0;
        if (i_accept) begin
            if (r_pos == '0) begin
                if (i_rx_byte == i_cfg.sync_value) begin
                    n_pos = POS_W'(1);
                end
            end else if (r_pos == POS_W'(1)) begin
                if ((i_rx_byte == '0) || (len_total > BUF_LIM)) begin
                    n_pos = '0;
                end else begin
                    n_pos   = POS_W'(2);
                    n_total = len_total[POS_W-1:0];
                end
            end else if (pos_inc == r_total) begin
                n_pos     = '0;
                load.load = (n_store[0] == i_cfg.channel_frame_type);
            end else begin
                n_pos = pos_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_total <= '0;
            for (int i = 0; i < STORE_BYTES; i++) begin
                r_store[i] <= '0;
            end
        end else begin
            r_pos   <= n_pos;
            r_total <= n_total;
            for (int i = 0; i < STORE_BYTES; i++) begin
                r_store[i] <= n_store[i];
            end
        end
    end

    assign o_load         = load;
    assign o_last_pending = (r_pos >= POS_W'(2)) && (pos_inc == r_total);

endmodule

// ===== design/rcfu_emitter.sv =====
// Channel emitter of the link frame channel unpacker: payload shift line and
// output register, one channel per beat. Depends on rcfu_pkg.
module rcfu_emitter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rcfu_pkg::t_frame_load            i_load,
    input  logic                             i_stall,
    output logic                             o_busy,
    output logic                             o_valid,
    output logic [rcfu_pkg::CHAN_IDX_W-1:0]  o_channel_index,
    output logic [rcfu_pkg::CHAN_BITS-1:0]   o_channel_value,
    output logic                             o_last_channel
);
    import rcfu_pkg::*;

    logic [PAYLOAD_W-1:0]  r_shift;
    logic [PAYLOAD_W-1:0]  n_shift;
    logic [CHAN_IDX_W-1:0] r_cnt;
    logic [CHAN_IDX_W-1:0] n_cnt;
    logic                  r_busy;
    logic                  n_busy;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [CHAN_IDX_W-1:0] r_out_index;
    logic [CHAN_IDX_W-1:0] n_out_index;
    logic [CHAN_BITS-1:0]  r_out_value;
    logic [CHAN_BITS-1:0]  n_out_value;
    logic                  r_out_last;
    logic                  n_out_last;
    logic                  out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_shift     = r_shift;
        n_cnt       = r_cnt;
        n_busy      = r_busy;
        n_out_valid = r_out_valid;
        n_out_index = r_out_index;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        if (out_free) begin
            if (r_busy) begin
                n_out_valid = 1'b1;
                n_out_index = r_cnt;
                n_out_value = r_shift[CHAN_BITS-1:0];
                n_out_last  = (r_cnt == LAST_CHANNEL);
                n_shift     = r_shift >> CHAN_BITS;
                n_cnt       = r_cnt + CHAN_IDX_W'(1);
                n_busy      = (r_cnt != LAST_CHANNEL);
            end else begin
                n_out_valid = 1'b0;
            end
        end
        if (i_load.load) begin
            n_shift = i_load.payload;
            n_cnt   = '0;
            n_busy  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift     <= n_shift;
        r_out_index <= n_out_index;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    assign o_busy          = r_busy;
    assign o_valid         = r_out_valid;
    assign o_channel_index = r_out_index;
    assign o_channel_value = r_out_value;
    assign o_last_channel  = r_out_last;

endmodule

// ===== design/rc_link_frame_channel_unpacker_core.sv =====
// Link frame channel unpacker, top level: one received byte per beat in,
// sixteen channel beats out for each completed channel frame.
// Channels pass shift line, output register; one per cycle unless stalled.
// Throughput: one byte per cycle; the last byte of any frame is held off
// until the last channel of the previous channel frame reaches the output.
// Reset: synchronous, active low; clears frame state, byte store, valid.
module rc_link_frame_channel_unpacker_core #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [rcfu_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rcfu_pkg::BYTE_W-1:0]      i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [rcfu_pkg::BYTE_W-1:0]      i_rx_byte,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [rcfu_pkg::CHAN_IDX_W-1:0]  o_channel_index,
    output logic [rcfu_pkg::CHAN_BITS-1:0]   o_channel_value,
    output logic                             o_last_channel
);
    import rcfu_pkg::*;

    t_cfg        cfg;
    t_frame_load load;
    logic        last_pending;
    logic        busy;
    logic        accept;

    assign o_stall = last_pending && busy;
    assign accept  = i_valid && !o_stall;

    rcfu_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rcfu_parser #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_rx_byte      (i_rx_byte),
        .i_cfg          (cfg),
        .o_load         (load),
        .o_last_pending (last_pending)
    );

    rcfu_emitter u_emitter (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (load),
        .i_stall         (i_stall),
        .o_busy          (busy),
        .o_valid         (o_valid),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_last_channel  (o_last_channel)
    );

endmodule

// ===== design/rcfu_checker.sv =====
// Port checker for the link frame channel unpacker, bound to the top level.
// Depends on rcfu_pkg.
module rcfu_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_stall,
    input logic                             o_valid,
    input logic                             i_stall,
    input logic [rcfu_pkg::CHAN_IDX_W-1:0]  o_channel_index,
    input logic [rcfu_pkg::CHAN_BITS-1:0]   o_channel_value,
    input logic                             o_last_channel
);
    import rcfu_pkg::*;

    a_stalled_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_channel_value))
        else $error("stalled channel beat changed");

    a_frame_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_channel |=>
            o_valid && (o_channel_index == $past(o_channel_index) + CHAN_IDX_W'(1)))
        else $error("channel run broken");

    a_start_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> (o_channel_index == '0))
        else $error("frame did not start at channel zero");

    a_last_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_channel |-> !o_stall)
        else $error("input held with no channels left to drain");

endmodule

bind rc_link_frame_channel_unpacker_core rcfu_checker u_rcfu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_channel_index (o_channel_index),
    .o_channel_value (o_channel_value),
    .o_last_channel  (o_last_channel)
);
